### hdl/mset_pkg.sv
// Shared types and constants for the multi-slot event timer table.
package mset_pkg;

	// Operation codes carried by the mode field
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_UNSET  = 2'd1,
		OP_TICK   = 2'd2,
		OP_CANCEL = 2'd3
	} mset_op_t;

	// Most fired beats reported for one tick
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		mset_op_t    mode;
		logic [15:0] event_id;
		logic [7:0]  owner_handle;
		logic [31:0] timeout_ms;
		logic        repeat_req;
		logic [15:0] tick_ms;
	} mset_item_t;

	// One slot as held in the slot RAM
	typedef struct packed {
		logic [15:0] ev;
		logic [7:0]  owner;
		logic        rep;
		logic [31:0] timeout;
		logic [31:0] elapsed;
	} mset_slot_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic flush;
	} mset_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stall;
		logic flush_done;
	} mset_sts_t;

endpackage

### hdl/mset_if.sv
// Handshake interfaces for the item and fired-event channels.
interface mset_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] event_id;
	logic [7:0]  owner_handle;
	logic [31:0] timeout_ms;
	logic        repeat_req;
	logic [15:0] tick_ms;

	modport source(output valid, mode, event_id, owner_handle, timeout_ms, repeat_req,
		tick_ms, input ready);
	modport sink(input valid, mode, event_id, owner_handle, timeout_ms, repeat_req,
		tick_ms, output ready);
endinterface

interface mset_fire_if;
	logic        valid;
	logic        ready;
	logic [15:0] fired_event;
	logic [7:0]  fired_owner;
	logic        last;

	modport source(output valid, fired_event, fired_owner, last, input ready);
	modport sink(input valid, fired_event, fired_owner, last, output ready);
endinterface

### hdl/mset_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mset_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/mset_ctrl.sv
// Sequencer: accepts an item, then for all but cancel walks the slots one per cycle unless stalled, and flushes.
module mset_ctrl #(
	parameter int unsigned SLOTS = 8,
	parameter int unsigned IW    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  mset_pkg::mset_op_t  item_mode,
	output logic                item_ready,
	input  mset_pkg::mset_sts_t sts,
	output mset_pkg::mset_cmd_t cmd,
	output logic [IW-1:0]       idx,
	output logic [IW-1:0]       rd_idx
);
	import mset_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	state_t        state_q;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (item_valid && item_mode != OP_CANCEL) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!sts.stall) begin
						if (idx_q == LAST) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (sts.flush_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		cmd.load   = item_valid && item_ready;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.flush  = (state_q == ST_FLUSH);
		idx        = idx_q;
		// slot 0 is read while idle so its data is ready on the first scan cycle
		rd_idx     = '0;
		if (state_q == ST_SCAN) begin
			if (sts.stall) begin
				rd_idx = idx_q;
			end else if (idx_q != LAST) begin
				rd_idx = idx_q + 1'b1;
			end
		end
	end
endmodule

### hdl/mset_dp.sv
// Datapath: slot RAM, used flags, tick arithmetic and fired-beat output stage.
module mset_dp #(
	parameter int unsigned SLOTS = 8,
	parameter int unsigned IW    = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mset_pkg::mset_cmd_t  cmd,
	input  logic [IW-1:0]        idx,
	input  logic [IW-1:0]        rd_idx,
	input  mset_pkg::mset_item_t item,
	input  logic                 fired_ready,
	output logic                 fired_valid,
	output logic [15:0]          fired_event,
	output logic [7:0]           fired_owner,
	output logic                 fired_last,
	output mset_pkg::mset_sts_t  sts
);
	import mset_pkg::*;

	localparam int unsigned SW = $bits(mset_slot_t);

	mset_item_t       item_q;
	logic [SLOTS-1:0] used_q;
	logic             set_done_q;
	logic [NW-1:0]    n_q;
	logic             pend_v_q;
	logic [15:0]      pend_event_q;
	logic [7:0]       pend_owner_q;
	logic             out_v_q;
	logic [15:0]      out_event_q;
	logic [7:0]       out_owner_q;
	logic             out_last_q;

	mset_slot_t    rd_slot;
	mset_slot_t    wr_slot;
	logic [SW-1:0] rd_word;
	logic          we;
	logic [32:0]   sum;
	logic [31:0]   sat;
	logic [32:0]   diff;
	logic          used_now;
	logic          fire;
	logic          report;
	logic          can_push;
	logic          advance;
	logic          push;

	mset_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx),
		.wdata (wr_slot),
		.raddr (rd_idx),
		.rdata (rd_word)
	);

	always_comb begin
		rd_slot  = mset_slot_t'(rd_word);
		used_now = used_q[idx];
		// saturating add, then one subtract gives both the compare and the reload
		sum      = {1'b0, rd_slot.elapsed} + {17'b0, item_q.tick_ms};
		sat      = sum[32] ? '1 : sum[31:0];
		diff     = {1'b0, sat} - {1'b0, rd_slot.timeout};
		fire     = (item_q.mode == OP_TICK) && used_now && !diff[32];
		report   = fire && (n_q < NW'(MAX_RESULTS));
		can_push = !out_v_q || fired_ready;

		sts.stall      = report && pend_v_q && !can_push;
		sts.flush_done = !pend_v_q || can_push;
		advance        = cmd.scan && !sts.stall;
		// a held beat moves to the output register during the walk or at flush
		push           = (advance && report && pend_v_q) ||
			(cmd.flush && pend_v_q && can_push);

		wr_slot = rd_slot;
		we      = 1'b0;
		case (item_q.mode)
			OP_SET: begin
				wr_slot.ev      = item_q.event_id;
				wr_slot.owner   = item_q.owner_handle;
				wr_slot.rep     = item_q.repeat_req;
				wr_slot.timeout = item_q.timeout_ms;
				wr_slot.elapsed = '0;
				we              = advance && !set_done_q && !used_now;
			end
			OP_TICK: begin
				wr_slot.elapsed = (fire && rd_slot.rep) ? diff[31:0] : sat;
				we              = advance && used_now;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (advance && report) begin
			pend_event_q <= rd_slot.ev;
			pend_owner_q <= rd_slot.owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			set_done_q <= 1'b0;
			n_q        <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_event_q <= '0;
			out_owner_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_v_q && fired_ready && !push) begin
				out_v_q <= 1'b0;
			end
			if (cmd.load) begin
				set_done_q <= 1'b0;
				n_q        <= '0;
				if (mset_op_t'(item.mode) == OP_CANCEL) begin
					used_q <= '0;
				end
			end
			if (advance) begin
				case (item_q.mode)
					OP_SET: begin
						if (!set_done_q && !used_now) begin
							used_q[idx] <= (item_q.event_id != 16'd0);
							set_done_q  <= 1'b1;
						end
					end
					OP_UNSET: begin
						if (used_now && rd_slot.ev == item_q.event_id) begin
							used_q[idx] <= 1'b0;
						end
					end
					OP_TICK: begin
						if (report) begin
							n_q      <= n_q + 1'b1;
							pend_v_q <= 1'b1;
							if (pend_v_q) begin
								out_v_q     <= 1'b1;
								out_event_q <= pend_event_q;
								out_owner_q <= pend_owner_q;
								out_last_q  <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.flush && pend_v_q && can_push) begin
				pend_v_q    <= 1'b0;
				out_v_q     <= 1'b1;
				out_event_q <= pend_event_q;
				out_owner_q <= pend_owner_q;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign fired_valid = out_v_q;
	assign fired_event = out_event_q;
	assign fired_owner = out_owner_q;
	assign fired_last  = out_last_q;
endmodule

### hdl/multi_slot_event_timer_table_core.sv
// Top level of the multi-slot event timer table.
//
// A table of SLOTS timer slots held in a small slot RAM, with one flip-flop
// per slot marking it in use (event id not zero); reset clears those flags at
// once, so there is no clearing pass. Set, unset and tick walk the slots one
// per cycle, unless the fired channel stalls, through the RAM's single read
// port; set and tick write a slot back once its registered read data arrives,
// while unset only clears its flag. An item passes through the walk, a flush
// that hands over the held final beat and a return to idle. Cancel clears all
// flags in the cycle it is accepted and does not walk. Tick fires slots in
// slot order, at most eight beats per tick, the final one marked with last.
// Each beat is held back one fire so that last can be known; the output
// register lets the next item start while a final beat waits to be taken.
module multi_slot_event_timer_table_core #(
	parameter int unsigned SLOTS = 8
) (
	input logic        clk,
	input logic        arst_n,
	mset_item_if.sink   item,
	mset_fire_if.source fired
);
	import mset_pkg::*;

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mset_cmd_t     cmd;
	mset_sts_t     sts;
	mset_item_t    item_pl;
	logic [IW-1:0] idx;
	logic [IW-1:0] rd_idx;

	always_comb begin
		item_pl.mode         = mset_op_t'(item.mode);
		item_pl.event_id     = item.event_id;
		item_pl.owner_handle = item.owner_handle;
		item_pl.timeout_ms   = item.timeout_ms;
		item_pl.repeat_req   = item.repeat_req;
		item_pl.tick_ms      = item.tick_ms;
	end

	// sequencer: owns the item handshake and the slot index
	mset_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item_pl.mode),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd),
		.idx        (idx),
		.rd_idx     (rd_idx)
	);

	// slot storage, tick arithmetic and fired-beat staging
	mset_dp #(.SLOTS(SLOTS), .IW(IW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.rd_idx      (rd_idx),
		.item        (item_pl),
		.fired_ready (fired.ready),
		.fired_valid (fired.valid),
		.fired_event (fired.fired_event),
		.fired_owner (fired.fired_owner),
		.fired_last  (fired.last),
		.sts         (sts)
	);
endmodule

### hdl/mset_chk.sv
// Port-level checks for the timer table, bound to the top level.
module mset_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_mode,
	input logic        fired_valid,
	input logic        fired_ready,
	input logic [15:0] fired_event,
	input logic [7:0]  fired_owner,
	input logic        fired_last
);
	import mset_pkg::*;

	// a scanning operation holds off the next item
	a_busy_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_mode != OP_CANCEL) |=> !item_ready)
		else $error("item taken during slot walk");

	// cancel completes in its own cycle
	a_cancel_single: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_mode == OP_CANCEL) |=> item_ready)
		else $error("cancel did not return to idle");

	// only used slots fire, so the event id is never zero
	a_event_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fired_valid |-> fired_event != 16'd0)
		else $error("fired beat with free event id");

	a_fired_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fired_valid && !fired_ready) |=> (fired_valid && $stable(fired_event)
			&& $stable(fired_owner) && $stable(fired_last)))
		else $error("stalled fired beat changed");
endmodule

bind multi_slot_event_timer_table_core mset_chk u_mset_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_mode   (item.mode),
	.fired_valid (fired.valid),
	.fired_ready (fired.ready),
	.fired_event (fired.fired_event),
	.fired_owner (fired.fired_owner),
	.fired_last  (fired.last)
);
